[sv/svms_pkg.sv]
// Shared types, constants and the log table function for the measurement statistics block.
package svms_pkg;

  // Field widths
  localparam int AMP_W     = 32;
  localparam int SQ_W      = 64;
  localparam int P_W       = 52;
  localparam int FRAC_BITS = 48;
  localparam int SUM_W     = 56;
  localparam int QMASK_W   = 30;
  localparam int LOGF_W    = 30;
  localparam int NLOG_W    = 36;
  localparam int PP_W      = 60;
  localparam int SHAMT_W   = 6;
  localparam int STEP_W    = 3;
  localparam int CFG_IDX_W = 2;

  // Normalizer: binary search over the 48-bit probability, 32/16/8/4/2/1
  localparam int NORM_STEPS = 6;

  localparam logic [27:0]      LN2_Q28 = 28'd186065280;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN = 2'd2;

  // Modes
  localparam logic MODE_PROB    = 1'b0;
  localparam logic MODE_ENTROPY = 1'b1;

  typedef struct packed {
    logic signed [AMP_W-1:0] amp_real;
    logic signed [AMP_W-1:0] amp_imag;
    logic                    last_amp;
  } in_t;

  typedef struct packed {
    logic [SUM_W-1:0] stat_value;
    logic             saturated;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic              load_in;
    logic              square;
    logic              sum_p;
    logic              norm_step;
    logic [STEP_W-1:0] step_idx;
    logic              table_rd;
    logic              ln_mul;
    logic              pp_mul;
    logic              term_calc;
    logic              acc;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mode;
    logic ent_skip;
    logic last;
    logic out_full;
  } sts_t;

  // log2(x) for x in Q1.30, 1 <= x < 2, by repeated squaring; Q0.30 truncated.
  // Only evaluated at elaboration to build the lookup table.
  function automatic logic [LOGF_W-1:0] log2_frac(input logic [63:0] x_in);
    logic [63:0]       x;
    logic [LOGF_W-1:0] r;
    x = x_in;
    r = '0;
    for (int b = LOGF_W - 1; b >= 0; b--) begin
      x = (x * x) >> 30;
      if (x >= 64'h0000_0000_8000_0000) begin
        x = x >> 1;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

[sv/svms_ctrl.sv]
// Sequencing state machine for the measurement statistics block.
module svms_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  svms_pkg::sts_t  sts,
  output svms_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_SUMP = 4'd2;
  localparam logic [3:0] S_NORM = 4'd3;
  localparam logic [3:0] S_LOOK = 4'd4;
  localparam logic [3:0] S_LN   = 4'd5;
  localparam logic [3:0] S_PP   = 4'd6;
  localparam logic [3:0] S_TERM = 4'd7;
  localparam logic [3:0] S_ACC  = 4'd8;

  localparam logic [svms_pkg::STEP_W-1:0] LAST_STEP =
    svms_pkg::STEP_W'(svms_pkg::NORM_STEPS - 1);

  logic [3:0]                    state_r, state_nxt;
  logic [svms_pkg::STEP_W-1:0]   step_r, step_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.step_idx = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_SQ;
        end
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = S_SUMP;
      end
      S_SUMP: begin
        cmd.sum_p = 1'b1;
        // probability mode and out-of-range entropy terms go straight to the adder
        if (sts.mode == svms_pkg::MODE_PROB || sts.ent_skip) begin
          state_nxt = S_ACC;
        end else begin
          step_nxt  = '0;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        cmd.norm_step = 1'b1;
        if (step_r == LAST_STEP) begin
          step_nxt  = '0;
          state_nxt = S_LOOK;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_LOOK: begin
        cmd.table_rd = 1'b1;
        state_nxt    = S_LN;
      end
      S_LN: begin
        cmd.ln_mul = 1'b1;
        state_nxt  = S_PP;
      end
      S_PP: begin
        cmd.pp_mul = 1'b1;
        state_nxt  = S_TERM;
      end
      S_TERM: begin
        cmd.term_calc = 1'b1;
        state_nxt     = S_ACC;
      end
      S_ACC: begin
        // a final amplitude waits here until the result register is free
        if (!(sts.last && sts.out_full)) begin
          cmd.acc   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

[sv/svms_dpath.sv]
// Datapath: config registers, squaring, log normalizer, entropy term and accumulator.
module svms_dpath #(
  parameter int MAX_QUBITS     = 30,
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  svms_pkg::cmd_t                      cmd,
  output svms_pkg::sts_t                      sts,
  input  svms_pkg::in_t                       in_data,
  input  logic                                cfg_we,
  input  logic [svms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [svms_pkg::QMASK_W-1:0]        cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output svms_pkg::out_t                      out_data
);

  localparam int IDX_W    = (MAX_QUBITS < svms_pkg::QMASK_W) ? MAX_QUBITS : svms_pkg::QMASK_W;
  localparam int TBL_SIZE = 1 << LOG_TABLE_BITS;
  localparam int FB       = svms_pkg::FRAC_BITS;
  localparam int SH       = svms_pkg::SHAMT_W;

  // Configuration registers
  logic                            mode_r;
  logic [svms_pkg::QMASK_W-1:0]    qmask_r;
  logic [svms_pkg::QMASK_W-1:0]    qpat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= svms_pkg::MODE_PROB;
      qmask_r <= '0;
      qpat_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        svms_pkg::CFG_MODE:    mode_r  <= cfg_data[0];
        svms_pkg::CFG_MASK:    qmask_r <= cfg_data;
        svms_pkg::CFG_PATTERN: qpat_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Log table, Q0.30, built at elaboration
  logic [svms_pkg::LOGF_W-1:0] log_tbl [TBL_SIZE];

  for (genvar g = 0; g < TBL_SIZE; g++) begin : g_log
    localparam logic [63:0] XV = (64'd1 << 30) + (64'(g) << (30 - LOG_TABLE_BITS));
    assign log_tbl[g] = svms_pkg::log2_frac(XV);
  end

  // Input capture
  logic [svms_pkg::AMP_W-1:0] re_r, im_r;
  logic                       last_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      re_r   <= in_data.amp_real;
      im_r   <= in_data.amp_imag;
      last_r <= in_data.last_amp;
    end
  end

  // Magnitude squares
  logic [svms_pkg::AMP_W-1:0] mag_re, mag_im;
  logic [svms_pkg::SQ_W-1:0]  sq_re_r, sq_im_r;

  assign mag_re = re_r[svms_pkg::AMP_W-1] ? (~re_r + 1'b1) : re_r;
  assign mag_im = im_r[svms_pkg::AMP_W-1] ? (~im_r + 1'b1) : im_r;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sq_re_r <= svms_pkg::SQ_W'(mag_re) * svms_pkg::SQ_W'(mag_re);
      sq_im_r <= svms_pkg::SQ_W'(mag_im) * svms_pkg::SQ_W'(mag_im);
    end
  end

  // p = re^2 + im^2 in Q4.60, cut to Q4.48
  logic [svms_pkg::SQ_W-1:0]    p60;
  logic [svms_pkg::P_W-1:0]     p48;
  logic                         ent_skip;
  logic [svms_pkg::QMASK_W-1:0] idx_ext;
  logic                         idx_match;
  logic [IDX_W-1:0]             idx_r;

  assign p60       = sq_re_r + sq_im_r;
  assign p48       = p60[svms_pkg::SQ_W-1:12];
  assign ent_skip  = (p48 == '0) || (p48[svms_pkg::P_W-1:FB] != '0);
  assign idx_ext   = svms_pkg::QMASK_W'(idx_r);
  assign idx_match = ((idx_ext & qmask_r) == (qpat_r & qmask_r));

  // Leading-one normalizer, one binary-search step per cycle
  logic [FB-1:0]  p48_r;
  logic [FB-1:0]  norm_r;
  logic [SH-1:0]  shamt_r;
  logic [SH-1:0]  step_sz;
  logic           top_zero;

  assign step_sz  = SH'(1 << (svms_pkg::NORM_STEPS - 1)) >> cmd.step_idx;
  assign top_zero = ((norm_r >> (SH'(FB) - step_sz)) == '0);

  // Entropy arithmetic
  logic [svms_pkg::LOGF_W-1:0] lg_r;
  logic [svms_pkg::NLOG_W-1:0] neg_log2;
  logic [63:0]                 ln_prod;
  logic [svms_pkg::NLOG_W-1:0] nln_r;
  logic [svms_pkg::PP_W-1:0]   x_r, y_r;
  logic [83:0]                 term_full;
  logic [svms_pkg::SUM_W-1:0]  term_r;

  // -log2 p in Q6.30: exponent is (48 - k) = shift + 1
  assign neg_log2  = {SH'(shamt_r + 1'b1), 30'd0} - {6'd0, lg_r};
  assign ln_prod   = 64'(neg_log2) * 64'(svms_pkg::LN2_Q28);
  assign term_full = {x_r, 24'd0} + 84'(y_r);

  always_ff @(posedge clk) begin
    if (cmd.sum_p) begin
      p48_r   <= p48[FB-1:0];
      norm_r  <= p48[FB-1:0];
      shamt_r <= '0;
      term_r  <= (mode_r == svms_pkg::MODE_PROB && idx_match) ?
                 svms_pkg::SUM_W'(p48) : '0;
    end
    if (cmd.norm_step && top_zero) begin
      norm_r  <= norm_r << step_sz;
      shamt_r <= shamt_r + step_sz;
    end
    if (cmd.table_rd) begin
      lg_r <= log_tbl[norm_r[FB-2 -: LOG_TABLE_BITS]];
    end
    if (cmd.ln_mul) begin
      nln_r <= ln_prod[63:28];
    end
    // p * (-ln p) split into two 24-bit halves of p
    if (cmd.pp_mul) begin
      x_r <= svms_pkg::PP_W'(p48_r[FB-1:24]) * svms_pkg::PP_W'(nln_r);
      y_r <= svms_pkg::PP_W'(p48_r[23:0]) * svms_pkg::PP_W'(nln_r);
    end
    if (cmd.term_calc) begin
      term_r <= svms_pkg::SUM_W'(term_full[83:30]);
    end
  end

  // Saturating accumulator
  logic [svms_pkg::SUM_W-1:0] run_r, run_nxt;
  logic                       sat_r, sat_nxt;
  logic [svms_pkg::SUM_W:0]   sum_ext;
  svms_pkg::out_t             out_r;
  logic                       out_valid_r;

  assign sum_ext = {1'b0, run_r} + {1'b0, term_r};
  assign run_nxt = sum_ext[svms_pkg::SUM_W] ? svms_pkg::SUM_MAX : sum_ext[svms_pkg::SUM_W-1:0];
  assign sat_nxt = sat_r | sum_ext[svms_pkg::SUM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= '0;
      sat_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.acc) begin
        if (last_r) begin
          run_r       <= '0;
          sat_r       <= 1'b0;
          idx_r       <= '0;
          out_valid_r <= 1'b1;
        end else begin
          run_r <= run_nxt;
          sat_r <= sat_nxt;
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  // Result holding register
  always_ff @(posedge clk) begin
    if (cmd.acc && last_r) begin
      out_r.stat_value <= run_nxt;
      out_r.saturated  <= sat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.mode     = mode_r;
  assign sts.ent_skip = ent_skip;
  assign sts.last     = last_r;
  assign sts.out_full = out_valid_r;

endmodule

[sv/state_vector_measurement_stats.sv]
// Top level of the state vector measurement statistics accumulator.
//
// Amplitudes (signed Q2.30 real and imaginary) arrive on the in_ channel in
// basis-index order; the block counts the index itself. In probability mode
// it sums re^2+im^2 over indexes matching the qubit mask and pattern; in
// entropy mode it sums -p ln p using a table-based logarithm.
// The amplitude flagged last_amp produces one out_ transfer carrying the
// Q8.48 sum (clamped at all ones) and the saturated flag, then the sum clears.
// Config registers are written over cfg_ (index 0 mode, 1 mask, 2 pattern);
// the user must do so only while no amplitude is in flight; the block does
// not enforce this, and cfg_ready is always high. One amplitude at a time is
// loaded, squared, summed and accumulated; in entropy mode the leading-one
// search, table read, ln2 multiply, two partial products and the term add
// come before the accumulate, but a zero or out-of-range p skips them. The
// result appears in the cycle after the final amplitude's accumulate cycle.
// A finished result sits in an output register; if the receiver stalls and a
// further last amplitude completes, that amplitude waits before accumulate.
// Synchronous active-low reset clears config, index, sum and the output valid.
module state_vector_measurement_stats #(
  parameter int MAX_QUBITS     = 30,
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  svms_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output svms_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [svms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [svms_pkg::QMASK_W-1:0]    cfg_data
);

  svms_pkg::cmd_t cmd;
  svms_pkg::sts_t sts;
  logic           cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  svms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  svms_dpath #(
    .MAX_QUBITS     (MAX_QUBITS),
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // at most one datapath operation per cycle
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_in, cmd.square, cmd.sum_p, cmd.norm_step, cmd.table_rd,
              cmd.ln_mul, cmd.pp_mul, cmd.term_calc, cmd.acc}))
    else $error("more than one datapath command active");

  // the engine is busy right after taking an amplitude
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while previous amplitude still in work");

  // a final accumulate never overwrites a pending result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.acc && sts.last) |-> !sts.out_full)
    else $error("result register overwritten");

  // saturation flag implies a clamped sum
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |-> (out_data.stat_value == svms_pkg::SUM_MAX))
    else $error("saturated result not at maximum");
`endif

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the state vector measurement statistics accumulator.
`timescale 1ns / 100ps

module tb_top;

  localparam int          CLK_PERIOD  = 20;
  localparam int          SETTLE_CYC  = 40;      // well past the entropy path
  localparam int          TARGET_AMPS = 1950;
  localparam logic [svms_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped register index
  localparam logic [29:0] ALL_QUBITS  = 30'h3FFF_FFFF;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  svms_pkg::in_t                   in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  svms_pkg::out_t                  out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [svms_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [svms_pkg::QMASK_W-1:0]    cfg_data  = '0;

  state_vector_measurement_stats u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Amplitudes waiting to be sent, stats waiting to be received
  svms_pkg::in_t  amp_queue[$];
  svms_pkg::out_t stat_expect[$];
  int   amps_queued = 0;
  int   mismatches  = 0;
  int   idle_pct    = 18;
  logic in_taken    = 1'b0;

  // Shadow copy of the block's registers and running state
  logic        ent_mode;
  logic [29:0] meas_mask;
  logic [29:0] meas_pattern;
  logic [29:0] basis_idx;
  logic [55:0] stat_sum;
  logic        stat_sat;
  logic [29:0] log2_lut [256];

  // Clock
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // log2(x), x in Q1.30 within [1,2), by repeated squaring; Q0.30 truncated
  function automatic logic [29:0] frac_log2(input logic [63:0] x_in);
    logic [63:0] x;
    logic [29:0] r;
    x = x_in;
    r = '0;
    for (int b = 29; b >= 0; b--) begin
      x = (x * x) >> 30;
      if (x >= 64'h8000_0000) begin
        x    = x >> 1;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

  // Square of a two's complement Q2.30 value, exact in Q4.60
  function automatic logic [63:0] amp_square(input logic [31:0] v);
    logic [31:0] m;
    m = v;
    if (v[31]) m = ~v + 32'd1;
    return {32'd0, m} * {32'd0, m};
  endfunction

  // -p ln p in Q8.48 for 0 < p < 1
  function automatic logic [55:0] neg_plogp(input logic [51:0] p48);
    int unsigned  k;
    logic [63:0]  lut_idx;
    logic [63:0]  nlog2;
    logic [63:0]  nln;
    logic [127:0] prod;
    k = 0;
    for (int b = 0; b < 48; b++)
      if (p48[b]) k = b;
    if (k >= 8) lut_idx = {12'd0, p48} >> (k - 8);
    else        lut_idx = {12'd0, p48} << (8 - k);
    lut_idx = lut_idx & 64'hFF;
    nlog2 = (64'(48 - k) << 30) - {34'd0, log2_lut[lut_idx[7:0]]};
    nln   = (nlog2 * {36'd0, svms_pkg::LN2_Q28}) >> 28;
    prod  = {76'd0, p48} * {64'd0, nln};
    return prod[85:30];
  endfunction

  // Fold one accepted amplitude into the shadow state; a last amplitude yields a stat
  task automatic accumulate_amp(input svms_pkg::in_t a);
    logic [51:0]    p48;
    logic [63:0]    p60;
    logic [55:0]    term;
    logic [56:0]    total;
    svms_pkg::out_t stat;
    p60  = amp_square(a.amp_real) + amp_square(a.amp_imag);
    p48  = p60[63:12];
    term = '0;
    if (ent_mode == svms_pkg::MODE_PROB) begin
      if ((basis_idx & meas_mask) == (meas_pattern & meas_mask)) term = {4'd0, p48};
    end else if (p48 != '0 && p48 < (52'd1 << svms_pkg::FRAC_BITS)) begin
      term = neg_plogp(p48);
    end
    total = {1'b0, stat_sum} + {1'b0, term};
    if (total > {1'b0, svms_pkg::SUM_MAX}) begin
      total    = {1'b0, svms_pkg::SUM_MAX};
      stat_sat = 1'b1;
    end
    stat_sum = total[55:0];
    if (a.last_amp) begin
      stat.stat_value = stat_sum;
      stat.saturated  = stat_sat;
      stat_expect.push_back(stat);
      stat_sum  = '0;
      stat_sat  = 1'b0;
      basis_idx = '0;
    end else begin
      basis_idx = basis_idx + 30'd1;
    end
  endtask

  // Input driver: next amplitude after each transfer, random gaps
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (amp_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_data  <= amp_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= idle_pct);
  end

  // Monitor: register writes, amplitude transfers, stat checks
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          svms_pkg::CFG_MODE:    ent_mode     = cfg_data[0];
          svms_pkg::CFG_MASK:    meas_mask    = cfg_data;
          svms_pkg::CFG_PATTERN: meas_pattern = cfg_data;
          default:               ;
        endcase
      end
      if (in_valid && in_ready) accumulate_amp(in_data);
      if (out_valid && out_ready) begin
        if (stat_expect.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected stat, expected none, actual value=%h sat=%b",
                   $time, out_data.stat_value, out_data.saturated);
        end else begin
          if (out_data.stat_value !== stat_expect[0].stat_value) begin
            mismatches++;
            $display("%0t: stat_value mismatch, expected %h actual %h",
                     $time, stat_expect[0].stat_value, out_data.stat_value);
          end
          if (out_data.saturated !== stat_expect[0].saturated) begin
            mismatches++;
            $display("%0t: saturated mismatch, expected %b actual %b",
                     $time, stat_expect[0].saturated, out_data.saturated);
          end
          void'(stat_expect.pop_front());
        end
      end
    end
  end

  task automatic queue_amp(input logic [31:0] re, input logic [31:0] im, input logic last);
    svms_pkg::in_t a;
    a.amp_real = re;
    a.amp_imag = im;
    a.last_amp = last;
    amp_queue.push_back(a);
    amps_queued++;
  endtask

  // Wait until every amplitude is sent, every stat received and the datapath is quiet
  task automatic drain();
    while (amp_queue.size() != 0 || in_valid) @(posedge clk);
    while (stat_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [svms_pkg::CFG_IDX_W-1:0] idx,
                           input logic [29:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_amp();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0:       v = $urandom();
      1:       v = $urandom() >> $urandom_range(0, 31);
      2:       v = $urandom_range(0, 32'h3FFF_FFFF);
      3:       v = '0;
      4:       v = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: v = $urandom_range(0, 32'h2000_0000);
    endcase
    if ($urandom_range(0, 1) != 0) v = -v;
    return v;
  endfunction

  // Stimulus
  initial begin
    int          n;
    int          len;
    int          pos;
    logic        close_vec;
    logic [29:0] mask_val;
    logic [29:0] pat_val;
    logic [31:0] re;
    logic [31:0] im;

    for (int i = 0; i < 256; i++)
      log2_lut[i] = frac_log2((64'd1 << 30) + (64'(i) << 22));
    ent_mode     = svms_pkg::MODE_PROB;
    meas_mask    = '0;
    meas_pattern = '0;
    basis_idx    = '0;
    stat_sum     = '0;
    stat_sat     = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Probability mode after reset: extremes and a single-amplitude vector
    queue_amp(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    queue_amp(32'h8000_0000, 32'h8000_0000, 1'b0);
    queue_amp(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
    queue_amp(32'h0000_0000, 32'h0000_0000, 1'b1);
    queue_amp(32'h4000_0000, 32'h0000_0000, 1'b1);
    drain();

    // Single qubit outcome one
    write_reg(svms_pkg::CFG_MASK, 30'd1);
    write_reg(svms_pkg::CFG_PATTERN, 30'd1);
    for (int i = 0; i < 4; i++) queue_amp(32'h2000_0000, 32'h0000_0000, i == 3);
    drain();

    // Two-qubit marginal, pattern bits outside the mask are don't-care
    write_reg(svms_pkg::CFG_MASK, 30'd5);
    write_reg(svms_pkg::CFG_PATTERN, ALL_QUBITS);
    for (int i = 0; i < 8; i++) queue_amp(32'h1000_0000, 32'hF000_0000, i == 7);
    drain();

    // Entropy mode: mask ignored, unmapped index write ignored
    write_reg(svms_pkg::CFG_MODE, 30'(svms_pkg::MODE_ENTROPY));
    write_reg(svms_pkg::CFG_MASK, ALL_QUBITS);
    write_reg(svms_pkg::CFG_PATTERN, 30'd0);
    write_reg(CFG_SPARE, 30'h3FFF_FFFE);
    queue_amp(32'h0000_0000, 32'h0000_0000, 1'b0);  // zero probability
    queue_amp(32'h0000_0003, 32'h0000_0000, 1'b0);  // below one LSB
    queue_amp(32'h0000_0040, 32'h0000_0000, 1'b0);  // exactly one LSB
    queue_amp(32'h4000_0000, 32'h0000_0000, 1'b0);  // p == 1
    queue_amp(32'h8000_0000, 32'h8000_0000, 1'b0);  // p > 1
    queue_amp(32'h2000_0000, 32'h2000_0000, 1'b0);  // p == 0.5
    queue_amp(32'h3FFF_FFFF, 32'h0000_0000, 1'b0);  // just under one
    queue_amp(32'h0B50_4F33, 32'hF4AF_B0CD, 1'b1);
    drain();

    // Accumulator overflow in probability mode
    write_reg(svms_pkg::CFG_MODE, 30'(svms_pkg::MODE_PROB));
    write_reg(svms_pkg::CFG_MASK, 30'd0);
    for (int i = 0; i < 40; i++) queue_amp(32'h8000_0000, 32'h8000_0000, i == 39);
    drain();

    // Accumulator overflow in entropy mode, p near 1/e (about 700 terms fill 256);
    // no idling on either side
    idle_pct = 0;
    write_reg(svms_pkg::CFG_MODE, 30'(svms_pkg::MODE_ENTROPY));
    for (int i = 0; i < 720; i++) begin
      re = 32'd651_000_000 + $urandom_range(0, 1_000_000);
      im = $urandom_range(0, 4095);
      if ($urandom_range(0, 1) != 0) im = -im;
      queue_amp(re, im, i == 719);
    end
    drain();
    idle_pct = 18;

    // Random phases: new settings, vectors of random length, sometimes left open
    while (amps_queued < TARGET_AMPS) begin
      case ($urandom_range(0, 3))
        0:       mask_val = '0;
        1:       mask_val = ALL_QUBITS;
        2:       mask_val = 30'($urandom_range(1, 15));
        default: mask_val = 30'($urandom());
      endcase
      case ($urandom_range(0, 2))
        0:       pat_val = 30'($urandom_range(0, 15));
        1:       pat_val = ALL_QUBITS;
        default: pat_val = 30'($urandom());
      endcase
      write_reg(svms_pkg::CFG_MODE, 30'($urandom_range(0, 1)));
      write_reg(svms_pkg::CFG_MASK, mask_val);
      write_reg(svms_pkg::CFG_PATTERN, pat_val);
      n         = $urandom_range(60, 200);
      close_vec = ($urandom_range(0, 3) != 0);
      pos       = 0;
      len       = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        queue_amp(rand_amp(), rand_amp(), (pos == len - 1) || (i == n - 1 && close_vec));
        pos++;
        if (pos == len) begin
          pos = 0;
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 12);
        end
      end
      drain();
    end

    if (mismatches == 0 && stat_expect.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
